@@ hdl/set_assoc_address_cache_fifo_defines.svh @@
// Assertion macros shared by the cache RTL.
`ifndef SET_ASSOC_ADDRESS_CACHE_FIFO_DEFINES_SVH
`define SET_ASSOC_ADDRESS_CACHE_FIFO_DEFINES_SVH

// Same-cycle implication, sampled on aclk, masked during reset.
`define SACF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, masked during reset.
`define SACF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sacf_pkg.sv @@
// Shared types and constants for the set-associative address cache.
`timescale 1ns / 1ps

package sacf_pkg;

    // Width of the stored key: address in the low 32 bits, family above.
    localparam int KEY_W        = 48;
    localparam int ADDR_W       = 32;
    localparam int FAMILY_W     = 16;
    localparam int OUT_TDATA_W  = 8;

    // Set selection from the low address byte.
    localparam int          BYTE_RANGE   = 256;
    localparam logic [7:0]  BYTE_MASK    = 8'hFF;
    localparam int          RECIP_SHIFT  = 16;

    // Operation codes carried on tuser.
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET,
        ST_META,
        ST_DECIDE,
        ST_SCAN,
        ST_RESULT
    } sacf_state_t;

endpackage

@@ hdl/sacf_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module sacf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/sacf_cmp.sv @@
// Key comparator shared across the way scan.
`timescale 1ns / 1ps

module sacf_cmp (
    input  logic                        en,
    input  logic [sacf_pkg::KEY_W-1:0]  key,
    input  logic [sacf_pkg::KEY_W-1:0]  entry,
    output logic                        match
);

    // Address and family must both agree.
    assign match = en
                   && (entry[sacf_pkg::ADDR_W-1:0] == key[sacf_pkg::ADDR_W-1:0])
                   && (entry[sacf_pkg::KEY_W-1:sacf_pkg::ADDR_W]
                       == key[sacf_pkg::KEY_W-1:sacf_pkg::ADDR_W]);

endmodule

@@ hdl/set_assoc_address_cache_fifo.sv @@
// Lookup time is set by the way scan: one entry RAM read per filled way until a match, one comparator.
// Transactions are taken one at a time; s_tready is low while an item is in work.
// Reset (aresetn low, synchronous): sequencer idle, output empty, all sets empty.
// Entry RAM is not cleared; per-set valid flags make unwritten metadata read as zero.
`timescale 1ns / 1ps

module set_assoc_address_cache_fifo #(
    parameter int SETS = 64,
    parameter int WAYS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] address, [47:32] family
    input  logic [0:0]  s_tuser,   // [0] op (0 lookup, 1 insert)
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] hit, [7:1] zero
);

`include "set_assoc_address_cache_fifo_defines.svh"

    // ---------------------------------------------------------------------
    // Derived sizes
    // ---------------------------------------------------------------------
    localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W    = $clog2(WAYS + 1);
    localparam int META_W   = CNT_W + WAY_W;
    localparam int ENTRIES  = SETS * WAYS;
    localparam int EA_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // Low-byte span per set, and its reciprocal for the divide-by-constant
    localparam int SPAN_RAW = sacf_pkg::BYTE_RANGE / SETS;
    localparam int SPAN     = (SPAN_RAW == 0) ? 1 : SPAN_RAW;
    localparam int RECIP    = (2 ** sacf_pkg::RECIP_SHIFT + SPAN - 1) / SPAN;
    localparam int RECIP_W  = sacf_pkg::RECIP_SHIFT + 1;
    localparam int PROD_W   = 8 + RECIP_W;
    localparam int QUOT_W   = PROD_W - sacf_pkg::RECIP_SHIFT;

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    sacf_pkg::sacf_state_t state_reg, state_next;

    logic                       op_reg;
    logic [sacf_pkg::KEY_W-1:0] key_reg;
    logic [SET_W-1:0]           set_reg;
    logic [EA_W-1:0]            base_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           idx_reg;
    logic                       pend_reg;
    logic                       hit_reg;
    logic                       m_tvalid_reg;
    logic                       m_hit_reg;
    logic [SETS-1:0]            valid_reg;   // set metadata written since reset

    // ---------------------------------------------------------------------
    // Combinational signals
    // ---------------------------------------------------------------------
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;
    logic [SET_W-1:0]  set_calc;

    logic [META_W-1:0] meta_rdata;
    logic [META_W-1:0] meta_wdata;
    logic [CNT_W-1:0]  cur_cnt;
    logic [WAY_W-1:0]  cur_ptr;
    logic [WAY_W-1:0]  ptr_adv;
    logic [WAY_W-1:0]  ins_way;
    logic              full;

    logic [sacf_pkg::KEY_W-1:0] ent_rdata;
    logic [EA_W-1:0]            ent_waddr;
    logic [EA_W-1:0]            ent_raddr;

    logic s_accept;
    logic meta_re;
    logic meta_we;
    logic ent_we;
    logic ent_re;
    logic scan_more;
    logic match;
    logic load_out;

    // ---------------------------------------------------------------------
    // Set index: low byte / SPAN via reciprocal multiply, saturated
    // ---------------------------------------------------------------------
    assign prod = PROD_W'(key_reg[7:0] & sacf_pkg::BYTE_MASK) * PROD_W'(RECIP);
    assign quot = prod[PROD_W-1:sacf_pkg::RECIP_SHIFT];
    assign set_calc = (quot > QUOT_W'(SETS - 1)) ? SET_W'(SETS - 1) : SET_W'(quot);

    // ---------------------------------------------------------------------
    // Set metadata: fill count and oldest pointer; empty until first insert
    // ---------------------------------------------------------------------
    assign cur_cnt = valid_reg[set_reg] ? meta_rdata[META_W-1:WAY_W] : '0;
    assign cur_ptr = valid_reg[set_reg] ? meta_rdata[WAY_W-1:0] : '0;
    assign full    = (cur_cnt == CNT_W'(WAYS));
    assign ptr_adv = (cur_ptr == WAY_W'(WAYS - 1)) ? '0 : cur_ptr + 1'b1;
    assign ins_way = full ? cur_ptr : cur_cnt[WAY_W-1:0];
    // Append while there is room, else overwrite oldest and move the pointer on
    assign meta_wdata = full ? {cur_cnt, ptr_adv} : {cur_cnt + 1'b1, cur_ptr};

    // Filled ways are always 0..count-1, so the scan walks them in index order
    assign scan_more = (idx_reg < cnt_reg);
    assign ent_waddr = base_reg + EA_W'(ins_way);
    assign ent_raddr = base_reg + EA_W'(idx_reg[WAY_W-1:0]);

    // ---------------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sacf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sacf_pkg::ST_SET;
                end
            end
            sacf_pkg::ST_SET:  state_next = sacf_pkg::ST_META;
            sacf_pkg::ST_META: state_next = sacf_pkg::ST_DECIDE;
            sacf_pkg::ST_DECIDE: begin
                if (op_reg == sacf_pkg::OP_INSERT) begin
                    state_next = sacf_pkg::ST_RESULT;
                end else begin
                    state_next = sacf_pkg::ST_SCAN;
                end
            end
            sacf_pkg::ST_SCAN: begin
                // stop early on a match, or once every filled way is compared
                if (match || (!scan_more && !pend_reg)) begin
                    state_next = sacf_pkg::ST_RESULT;
                end
            end
            sacf_pkg::ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = sacf_pkg::ST_IDLE;
                end
            end
            default: state_next = sacf_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer outputs
    // ---------------------------------------------------------------------
    always_comb begin
        s_tready = 1'b0;
        meta_re  = 1'b0;
        meta_we  = 1'b0;
        ent_we   = 1'b0;
        ent_re   = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            sacf_pkg::ST_IDLE:   s_tready = 1'b1;
            sacf_pkg::ST_SET:    ;
            sacf_pkg::ST_META:   meta_re = 1'b1;
            sacf_pkg::ST_DECIDE: begin
                meta_we = (op_reg == sacf_pkg::OP_INSERT);
                ent_we  = (op_reg == sacf_pkg::OP_INSERT);
            end
            sacf_pkg::ST_SCAN:   ent_re = scan_more;
            sacf_pkg::ST_RESULT: load_out = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    assign s_accept = s_tvalid && s_tready;

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sacf_pkg::ST_IDLE;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            valid_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= ent_re;
            if (meta_we) begin
                valid_reg[set_reg] <= 1'b1;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg  <= s_tuser[0];
            key_reg <= s_tdata;
        end
        if (state_reg == sacf_pkg::ST_SET) begin
            set_reg <= set_calc;
        end
        if (state_reg == sacf_pkg::ST_META) begin
            base_reg <= EA_W'(int'(set_reg) * WAYS);
        end
        if (state_reg == sacf_pkg::ST_DECIDE) begin
            cnt_reg <= cur_cnt;
            idx_reg <= '0;
            hit_reg <= 1'b0;
        end
        if (ent_re) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (match) begin
            hit_reg <= 1'b1;
        end
        if (load_out) begin
            m_hit_reg <= hit_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(sacf_pkg::OUT_TDATA_W - 1){1'b0}}, m_hit_reg};

    // ---------------------------------------------------------------------
    // Storage and compare unit
    // ---------------------------------------------------------------------
    sacf_ram #(
        .WIDTH (META_W),
        .DEPTH (SETS)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (set_reg),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (set_reg),
        .rdata (meta_rdata)
    );

    sacf_ram #(
        .WIDTH (sacf_pkg::KEY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (key_reg),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    sacf_cmp u_cmp (
        .en    (pend_reg && (state_reg == sacf_pkg::ST_SCAN)),
        .key   (key_reg),
        .entry (ent_rdata),
        .match (match)
    );

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `SACF_ASSERT_IMP(a_scan_bound, ent_re, (idx_reg < cnt_reg) && (op_reg == sacf_pkg::OP_LOOKUP), "scan read past fill count or during insert")
    `SACF_ASSERT_NXT(a_valid_set, meta_we, valid_reg[$past(set_reg)], "set not marked valid after insert")
    `SACF_ASSERT_IMP(a_insert_no_hit, load_out && (op_reg == sacf_pkg::OP_INSERT), !hit_reg, "insert reported a hit")
    `SACF_ASSERT_IMP(a_hit_exits, state_reg == sacf_pkg::ST_SCAN, !hit_reg, "scan continued after a hit")

endmodule
